// File: rtl/e2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants, types and arithmetic helpers for the Euler angle to
// quaternion converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int LANES    = 3;
    localparam int INT_FRAC = 30;
    localparam int XY_W     = 34;
    localparam int Z_W      = 34;
    localparam int TRIG_W   = 32;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_lane_t;

    typedef cordic_lane_t [LANES-1:0] cordic_vec_t;

    // arctangent of 2^-stage, 2^31 equals pi
    function automatic logic signed [Z_W-1:0] atan_step(input int stage);
        logic signed [Z_W-1:0] t;
        begin
            case (stage)
                0:       t = 34'sd536870912;
                1:       t = 34'sd316933406;
                2:       t = 34'sd167458907;
                3:       t = 34'sd85004756;
                4:       t = 34'sd42667331;
                5:       t = 34'sd21354465;
                6:       t = 34'sd10680862;
                7:       t = 34'sd5340245;
                8:       t = 34'sd2670163;
                9:       t = 34'sd1335087;
                10:      t = 34'sd667544;
                11:      t = 34'sd333772;
                12:      t = 34'sd166886;
                13:      t = 34'sd83443;
                14:      t = 34'sd41722;
                15:      t = 34'sd20861;
                16:      t = 34'sd10430;
                17:      t = 34'sd5215;
                18:      t = 34'sd2608;
                19:      t = 34'sd1304;
                20:      t = 34'sd652;
                21:      t = 34'sd326;
                22:      t = 34'sd163;
                23:      t = 34'sd81;
                24:      t = 34'sd41;
                25:      t = 34'sd20;
                26:      t = 34'sd10;
                27:      t = 34'sd5;
                28:      t = 34'sd3;
                29:      t = 34'sd1;
                30:      t = 34'sd1;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

    // Q30 x Q30 -> Q30, floor
    function automatic logic signed [TRIG_W-1:0] mul_q(
        input logic signed [TRIG_W-1:0] a,
        input logic signed [TRIG_W-1:0] b
    );
        logic signed [2*TRIG_W-1:0] p;
        begin
            p = a * b;
            return p[INT_FRAC +: TRIG_W];
        end
    endfunction

endpackage

// File: rtl/e2q_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_cordic_cell
// One rotation-mode CORDIC iteration for the three angle lanes, registered,
// with a valid/ready hop to the next cell.
// ----------------------------------------------------------------------------
module e2q_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  e2q_pkg::cordic_vec_t in_lane,
    output logic                 out_valid,
    input  logic                 out_ready,
    output e2q_pkg::cordic_vec_t out_lane
);
    import e2q_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = atan_step(STAGE);

    logic        valid_reg;
    logic        valid_next;
    cordic_vec_t lane_reg;
    cordic_vec_t lane_next;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (!in_lane[l].z[Z_W-1])
            begin
                lane_next[l].x = in_lane[l].x - (in_lane[l].y >>> STAGE);
                lane_next[l].y = in_lane[l].y + (in_lane[l].x >>> STAGE);
                lane_next[l].z = in_lane[l].z - ATAN;
            end
            else
            begin
                lane_next[l].x = in_lane[l].x + (in_lane[l].y >>> STAGE);
                lane_next[l].y = in_lane[l].y - (in_lane[l].x >>> STAGE);
                lane_next[l].z = in_lane[l].z + ATAN;
            end
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            lane_reg <= lane_next;
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

// File: rtl/e2q_quat_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_quat_mult
// Three-stage product pipeline: pair products, triple products, then sum,
// round and clamp into the output register.
// ----------------------------------------------------------------------------
module e2q_quat_mult #(
    parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [e2q_pkg::TRIG_W-1:0]     cos_r,
    input  logic signed [e2q_pkg::TRIG_W-1:0]     sin_r,
    input  logic signed [e2q_pkg::TRIG_W-1:0]     cos_p,
    input  logic signed [e2q_pkg::TRIG_W-1:0]     sin_p,
    input  logic signed [e2q_pkg::TRIG_W-1:0]     cos_y,
    input  logic signed [e2q_pkg::TRIG_W-1:0]     sin_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [OUT_FRAC_BITS+1:0]       quat_w,
    output logic signed [OUT_FRAC_BITS+1:0]       quat_x,
    output logic signed [OUT_FRAC_BITS+1:0]       quat_y,
    output logic signed [OUT_FRAC_BITS+1:0]       quat_z
);
    import e2q_pkg::*;

    localparam int OW = OUT_FRAC_BITS + 2;
    localparam int SW = TRIG_W + 1;
    localparam int RW = TRIG_W + 2;
    localparam int SH = INT_FRAC - OUT_FRAC_BITS;
    localparam logic signed [RW-1:0] RND = (RW'(1) <<< SH) >>> 1;
    localparam logic signed [RW-1:0] ONE = RW'(1) <<< OUT_FRAC_BITS;

    function automatic logic signed [OW-1:0] to_out(input logic signed [SW-1:0] s);
        logic signed [RW-1:0] t;
        begin
            t = (RW'(s) + RND) >>> SH;
            if (t > ONE)
                t = ONE;
            if (t < -ONE)
                t = -ONE;
            return t[OW-1:0];
        end
    endfunction

    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    logic signed [TRIG_W-1:0] crcp_reg, srsp_reg, srcp_reg, crsp_reg, cy_reg, sy_reg;
    logic signed [TRIG_W-1:0] a1_reg, a2_reg, b1_reg, b2_reg;
    logic signed [TRIG_W-1:0] c1_reg, c2_reg, d1_reg, d2_reg;
    logic signed [OW-1:0]     qw_reg, qx_reg, qy_reg, qz_reg;

    logic signed [SW-1:0] w_sum, x_sum, y_sum, z_sum;

    assign r3 = !v3_reg || out_ready;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= in_valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && r1)
        begin
            crcp_reg <= mul_q(cos_r, cos_p);
            srsp_reg <= mul_q(sin_r, sin_p);
            srcp_reg <= mul_q(sin_r, cos_p);
            crsp_reg <= mul_q(cos_r, sin_p);
            cy_reg   <= cos_y;
            sy_reg   <= sin_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && r2)
        begin
            a1_reg <= mul_q(crcp_reg, cy_reg);
            a2_reg <= mul_q(srsp_reg, sy_reg);
            b1_reg <= mul_q(srcp_reg, cy_reg);
            b2_reg <= mul_q(crsp_reg, sy_reg);
            c1_reg <= mul_q(crsp_reg, cy_reg);
            c2_reg <= mul_q(srcp_reg, sy_reg);
            d1_reg <= mul_q(crcp_reg, sy_reg);
            d2_reg <= mul_q(srsp_reg, cy_reg);
        end
    end

    assign w_sum = SW'(a1_reg) + SW'(a2_reg);
    assign x_sum = SW'(b1_reg) - SW'(b2_reg);
    assign y_sum = SW'(c1_reg) + SW'(c2_reg);
    assign z_sum = SW'(d1_reg) - SW'(d2_reg);

    always_ff @(posedge clk)
    begin
        if (v2_reg && r3)
        begin
            qw_reg <= to_out(w_sum);
            qx_reg <= to_out(x_sum);
            qy_reg <= to_out(y_sum);
            qz_reg <= to_out(z_sum);
        end
    end

    assign out_valid = v3_reg;
    assign quat_w    = qw_reg;
    assign quat_x    = qx_reg;
    assign quat_y    = qy_reg;
    assign quat_z    = qz_reg;

endmodule

// File: rtl/euler_to_quaternion_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_unit
// Roll/pitch/yaw binary angles to a Q1.OUT_FRAC_BITS unit quaternion.
//
// Input stream: one beat carries roll, pitch and yaw (2^(ANGLE_BITS-1) = pi).
// Output stream: one beat per input beat with w, x, y, z, clamped to +/-1.
// Each angle is halved and fed through a row of CORDIC_STAGES cells, one
// rotation per cell, all three angles side by side. Three product stages
// follow: pair products, triple products, then sum/round/clamp.
// Throughput: one beat per cycle while m_axis_tready is high; every
// stage has its own valid bit, so bubbles are squeezed out and new beats
// enter while a result waits.
// Stall: when m_axis_tready is low the output holds; upstream stages keep
// filling until the row is full, then s_axis_tready drops.
// Reset: all valid bits clear; the data registers are not reset.
// ----------------------------------------------------------------------------
module euler_to_quaternion_unit #(
    parameter int ANGLE_BITS    = e2q_pkg::ANGLE_BITS_DEF,
    parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF,
    localparam int IN_TDATA_W   = ((3 * ANGLE_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W  = ((4 * (OUT_FRAC_BITS + 2) + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // roll_angle, pitch_angle, yaw_angle
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // quat_w, quat_x, quat_y, quat_z
);
    import e2q_pkg::*;

    localparam int OW = OUT_FRAC_BITS + 2;

    logic        cell_valid [CORDIC_STAGES+1];
    logic        cell_ready [CORDIC_STAGES+1];
    cordic_vec_t cell_lane  [CORDIC_STAGES+1];

    logic signed [OW-1:0] quat_w, quat_x, quat_y, quat_z;

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_seed
            logic signed [ANGLE_BITS-1:0] ang;
            assign ang = $signed(s_axis_tdata[g*ANGLE_BITS +: ANGLE_BITS]);
            assign cell_lane[0][g].x = CORDIC_GAIN;
            assign cell_lane[0][g].y = '0;
            if (ANGLE_BITS <= 31)
            begin : g_up
                assign cell_lane[0][g].z = Z_W'(ang) <<< (31 - ANGLE_BITS);
            end
            else
            begin : g_dn
                assign cell_lane[0][g].z = Z_W'(ang) >>> (ANGLE_BITS - 31);
            end
        end

        for (g = 0; g < CORDIC_STAGES; g++)
        begin : g_cell
            e2q_cordic_cell #(
                .STAGE(g)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .in_valid (cell_valid[g]),
                .in_ready (cell_ready[g]),
                .in_lane  (cell_lane[g]),
                .out_valid(cell_valid[g+1]),
                .out_ready(cell_ready[g+1]),
                .out_lane (cell_lane[g+1])
            );
        end
    endgenerate

    assign cell_valid[0] = s_axis_tvalid;
    assign s_axis_tready = cell_ready[0];

    e2q_quat_mult #(
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cell_valid[CORDIC_STAGES]),
        .in_ready (cell_ready[CORDIC_STAGES]),
        .cos_r    (cell_lane[CORDIC_STAGES][0].x[TRIG_W-1:0]),
        .sin_r    (cell_lane[CORDIC_STAGES][0].y[TRIG_W-1:0]),
        .cos_p    (cell_lane[CORDIC_STAGES][1].x[TRIG_W-1:0]),
        .sin_p    (cell_lane[CORDIC_STAGES][1].y[TRIG_W-1:0]),
        .cos_y    (cell_lane[CORDIC_STAGES][2].x[TRIG_W-1:0]),
        .sin_y    (cell_lane[CORDIC_STAGES][2].y[TRIG_W-1:0]),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .quat_w   (quat_w),
        .quat_x   (quat_x),
        .quat_y   (quat_y),
        .quat_z   (quat_z)
    );

    assign m_axis_tdata = OUT_TDATA_W'({quat_z, quat_y, quat_x, quat_w});

endmodule

// File: rtl/e2q_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_checker
// Port-level checks for euler_to_quaternion_unit, bound to the top level.
// ----------------------------------------------------------------------------
module e2q_checker #(
    parameter int OUT_FRAC_BITS = e2q_pkg::OUT_FRAC_BITS_DEF,
    parameter int OUT_TDATA_W   = 64
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);
    localparam int OW = OUT_FRAC_BITS + 2;
    localparam logic signed [OW-1:0] ONE = OW'(1) <<< OUT_FRAC_BITS;

    logic signed [OW-1:0] qw, qx, qy, qz;

    assign qw = $signed(m_axis_tdata[0*OW +: OW]);
    assign qx = $signed(m_axis_tdata[1*OW +: OW]);
    assign qy = $signed(m_axis_tdata[2*OW +: OW]);
    assign qz = $signed(m_axis_tdata[3*OW +: OW]);

    // stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

    // components clamped to +/- one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (qw <= ONE) && (qw >= -ONE) && (qx <= ONE) && (qx >= -ONE)
                       && (qy <= ONE) && (qy >= -ONE) && (qz <= ONE) && (qz >= -ONE))
    else $error("quaternion component out of range");

    // no beat during reset
    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind euler_to_quaternion_unit e2q_checker #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS),
    .OUT_TDATA_W  (OUT_TDATA_W)
) u_e2q_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

// File: tb/sv/tb_euler_to_quaternion_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_to_quaternion_unit
// Streams roll/pitch/yaw triples into the converter: first a directed set of
// corner angles, then random ones. Every output beat is checked against a
// fixed-point model of the half-angle CORDIC and the triple products. Both
// stream sides toggle valid/ready at random in three phases with different
// idle rates.
// ----------------------------------------------------------------------------
module tb_euler_to_quaternion_unit;

    localparam int  ANGLE_W    = e2q_pkg::ANGLE_BITS_DEF;
    localparam int  QUAT_W     = e2q_pkg::OUT_FRAC_BITS_DEF + 2;
    localparam int  ROTATIONS  = e2q_pkg::CORDIC_STAGES_DEF;
    localparam int  IN_W       = ((3 * ANGLE_W + 7) / 8) * 8;
    localparam int  OUT_W      = ((4 * QUAT_W + 7) / 8) * 8;
    localparam int  PIPE_DEPTH = ROTATIONS + 3;
    localparam int  RAND_ITEMS = 1300;
    localparam int  CYCLE_CAP  = 400000;

    typedef struct packed {
        logic signed [QUAT_W-1:0] z;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] w;
    } quat_t;

    class quat_scoreboard;
        quat_t quat_q[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        function longint arc_step(int i);
            longint tbl[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                                21354465, 10680862, 5340245, 2670163, 1335087, 667544,
                                333772, 166886, 83443, 41722, 20861};
            return tbl[i];
        endfunction

        // half angle in units where 2^31 is pi
        function longint half_angle(logic [ANGLE_W-1:0] raw);
            longint a;
            a = longint'($signed(raw));
            return (a * (64'sd1 <<< 31)) >>> ANGLE_W;
        endfunction

        function void rotate(input longint ang, output longint c, output longint s);
            longint px, py, pz, dx, dy;
            px = 64'sd652032874;
            py = 0;
            pz = ang;
            for (int i = 0; i < ROTATIONS; i++)
            begin
                dx = py >>> i;
                dy = px >>> i;
                if (pz >= 0)
                begin
                    px = px - dx;
                    py = py + dy;
                    pz = pz - arc_step(i);
                end
                else
                begin
                    px = px + dx;
                    py = py - dy;
                    pz = pz + arc_step(i);
                end
            end
            c = px;
            s = py;
        endfunction

        function longint q30_mul(longint a, longint b);
            return (a * b) >>> 30;
        endfunction

        function logic signed [QUAT_W-1:0] to_q14(longint v);
            longint r;
            longint one;
            one = 64'sd1 <<< (QUAT_W - 2);
            r = (v + (64'sd1 <<< (29 - (QUAT_W - 2)))) >>> (30 - (QUAT_W - 2));
            if (r > one)
                r = one;
            if (r < -one)
                r = -one;
            return r[QUAT_W-1:0];
        endfunction

        function quat_t predict_quat(logic [ANGLE_W-1:0] roll, logic [ANGLE_W-1:0] pitch,
                                     logic [ANGLE_W-1:0] yaw);
            longint cr, sr, cp, sp, cy, sy;
            longint crcp, srsp, srcp, crsp;
            quat_t  q;
            rotate(half_angle(roll), cr, sr);
            rotate(half_angle(pitch), cp, sp);
            rotate(half_angle(yaw), cy, sy);
            crcp = q30_mul(cr, cp);
            srsp = q30_mul(sr, sp);
            srcp = q30_mul(sr, cp);
            crsp = q30_mul(cr, sp);
            q.w = to_q14(q30_mul(crcp, cy) + q30_mul(srsp, sy));
            q.x = to_q14(q30_mul(srcp, cy) - q30_mul(crsp, sy));
            q.y = to_q14(q30_mul(crsp, cy) + q30_mul(srcp, sy));
            q.z = to_q14(q30_mul(crcp, sy) - q30_mul(srsp, cy));
            return q;
        endfunction

        function void note_angles(logic [ANGLE_W-1:0] roll, logic [ANGLE_W-1:0] pitch,
                                  logic [ANGLE_W-1:0] yaw);
            quat_q = {quat_q, predict_quat(roll, pitch, yaw)};
        endfunction

        function void check_quat(logic [OUT_W-1:0] data);
            quat_t exp_q;
            quat_t got_q;
            string names[4];
            names = '{"quat_w", "quat_x", "quat_y", "quat_z"};
            if (quat_q.size() == 0)
            begin
                $error("output beat with nothing expected: %h", data);
                errors++;
                return;
            end
            exp_q = quat_q.pop_front();
            got_q = data[4*QUAT_W-1:0];
            for (int f = 0; f < 4; f++)
            begin
                if (got_q[f*QUAT_W +: QUAT_W] !== exp_q[f*QUAT_W +: QUAT_W])
                begin
                    $error("%s mismatch: expected %0d, got %0d", names[f],
                           $signed(exp_q[f*QUAT_W +: QUAT_W]),
                           $signed(got_q[f*QUAT_W +: QUAT_W]));
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return quat_q.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             cycle_cnt     = 0;
    quat_scoreboard sb            = new();

    euler_to_quaternion_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // roll_angle, pitch_angle, yaw_angle
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // quat_w, quat_x, quat_y, quat_z
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // output side: check accepted beats, random backpressure
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_quat(m_axis_tdata);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic push_angles(input logic [ANGLE_W-1:0] roll, input logic [ANGLE_W-1:0] pitch,
                               input logic [ANGLE_W-1:0] yaw);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({yaw, pitch, roll});
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_angles(roll, pitch, yaw);
    endtask

    function automatic logic [ANGLE_W-1:0] pick_angle();
        logic [ANGLE_W-1:0] corners[8];
        corners = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff,
                    16'h0001, 16'h4000, 16'hc000, 16'h8001};
        if ($urandom_range(0, 9) == 0)
            return corners[$urandom_range(0, 7)];
        return ANGLE_W'($urandom);
    endfunction

    task automatic push_random(input int count);
        for (int n = 0; n < count; n++)
            push_angles(pick_angle(), pick_angle(), pick_angle());
    endtask

    initial
    begin
        logic [ANGLE_W-1:0] corner_set[18][3];
        rst_n <= 1'b0;
        corner_set = '{
            '{16'h0000, 16'h0000, 16'h0000}, '{16'h8000, 16'h0000, 16'h0000},
            '{16'h0000, 16'h8000, 16'h0000}, '{16'h0000, 16'h0000, 16'h8000},
            '{16'h7fff, 16'h7fff, 16'h7fff}, '{16'h8000, 16'h8000, 16'h8000},
            '{16'h4000, 16'h0000, 16'h0000}, '{16'h0000, 16'h4000, 16'h0000},
            '{16'h0000, 16'h0000, 16'h4000}, '{16'hc000, 16'hc000, 16'hc000},
            '{16'hffff, 16'hffff, 16'hffff}, '{16'h0001, 16'h0001, 16'h0001},
            '{16'h4000, 16'h4000, 16'h4000}, '{16'h8000, 16'h7fff, 16'h8000},
            '{16'h2000, 16'he000, 16'h6000}, '{16'h7fff, 16'h8000, 16'h7fff},
            '{16'hc000, 16'h4000, 16'hc000}, '{16'h8001, 16'h8001, 16'h8001}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 68;
        foreach (corner_set[i])
            push_angles(corner_set[i][0], corner_set[i][1], corner_set[i][2]);
        push_random(RAND_ITEMS / 3);

        send_idle_pct = 68;
        recv_idle_pct = 32;
        push_random(RAND_ITEMS / 3);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        push_random(RAND_ITEMS - 2 * (RAND_ITEMS / 3));
        s_axis_tvalid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
